FILE: sv/sorted_key_set_core_macros.svh
// assertion helpers used by the checker file
`ifndef SORTED_KEY_SET_CORE_MACROS_SVH
`define SORTED_KEY_SET_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SKS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_set_core: check failed");

// next-cycle implication, disabled while reset is low
`define SKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_set_core: check failed");

`endif

FILE: sv/sks_pkg.sv
`default_nettype none
package sks_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_BITS_DEF = 64;
  localparam int unsigned KEY_PORT_W   = 64;
  localparam int unsigned FIELD_W      = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_MISS = 2'd2,
    STAT_FULL = 2'd3
  } status_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/sks_cell.sv
`default_nettype none
module sks_cell #(
  parameter int unsigned KeyBits = 64,
  parameter int unsigned PosW    = 7,
  parameter int unsigned Idx     = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sks_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [KeyBits-1:0] key_i,
  input  wire logic [KeyBits-1:0] left_key_i,
  input  wire logic               left_valid_i,
  input  wire logic               left_lt_i,
  input  wire logic [KeyBits-1:0] right_key_i,
  input  wire logic               right_valid_i,
  input  wire logic               right_lt_i,
  output logic      [KeyBits-1:0] key_o,
  output logic                    valid_o,
  output logic                    lt_o,
  output logic                    hit_o,
  output logic      [PosW-1:0]    pos_o
);
  import sks_pkg::*;

  logic [KeyBits-1:0] key_q, key_d;
  logic               valid_q, valid_d;
  logic               lt_q, lt_d;
  logic               eq_q, eq_d;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    lt_d    = lt_q;
    eq_d    = eq_q;
    if (ctrl_i.cmp) begin
      lt_d = valid_q & (key_q < key_i);
      eq_d = valid_q & (key_q == key_i);
    end
    if (ctrl_i.ins && !lt_q) begin
      // first cell not below the key takes it, the rest take the left neighbor
      if (left_lt_i) begin
        key_d   = key_i;
        valid_d = 1'b1;
      end else begin
        key_d   = left_key_i;
        valid_d = left_valid_i;
      end
    end
    if (ctrl_i.del && !lt_q) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign lt_o    = lt_q;
  assign hit_o   = eq_q;
  // last cell below the key marks the lower bound
  assign pos_o   = (lt_q && !right_lt_i) ? PosW'(Idx + 1) : '0;

endmodule
`default_nettype wire

FILE: sv/sorted_key_set_core.sv
`default_nettype none
// Sorted key set held in a row of CAPACITY cells, one key per cell, in
// ascending order. An operation is taken when start is high and busy is low;
// busy then stays high through the compare and update states (every cell
// compares its key with the search key in parallel, then the row shifts by
// one place on an insert or a delete), and the result is shown for exactly
// one cycle on valid_o in the first cycle in which busy is low again; a new
// start may be given in that same result cycle. The receiver cannot hold a
// result off: sample status_o, position_o and entry_count_o whenever valid_o
// is high. The longest path is the key compare in each cell and, in the next
// cycle, the OR of the cells' lower-bound positions across the row.
module sorted_key_set_core #(
  parameter int unsigned CAPACITY = sks_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = sks_pkg::KEY_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      operation_i,
  input  wire logic [sks_pkg::KEY_PORT_W-1:0]  key_i,
  output logic                                 valid_o,
  output logic      [1:0]                      status_o,
  output logic      [sks_pkg::FIELD_W-1:0]     position_o,
  output logic      [sks_pkg::FIELD_W-1:0]     entry_count_o
);
  import sks_pkg::*;

  localparam int unsigned PosW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [1:0]          op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [PosW-1:0]     cnt_q, cnt_d;
  logic                res_valid_q;
  logic [1:0]          status_q, status_d;
  logic [FIELD_W-1:0]  pos_q, cnt_out_q;
  cell_ctrl_t          ctrl;
  logic                present, full;
  logic [PosW-1:0]     pos_all;

  logic [KEY_BITS-1:0] cell_key [CAPACITY+1];
  logic                cell_valid [CAPACITY+1];
  logic                cell_lt [CAPACITY+1];
  logic                cell_hit [CAPACITY];
  logic [PosW-1:0]     cell_pos [CAPACITY];

  // sentinel past the last cell
  assign cell_key[CAPACITY]   = '0;
  assign cell_valid[CAPACITY] = 1'b0;
  assign cell_lt[CAPACITY]    = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0] lkey;
    logic                lvalid, llt;
    if (g == 0) begin : g_first
      assign lkey   = '0;
      assign lvalid = 1'b1;
      assign llt    = 1'b1;
    end else begin : g_rest
      assign lkey   = cell_key[g-1];
      assign lvalid = cell_valid[g-1];
      assign llt    = cell_lt[g-1];
    end
    sks_cell #(
      .KeyBits(KEY_BITS),
      .PosW   (PosW),
      .Idx    (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .left_key_i   (lkey),
      .left_valid_i (lvalid),
      .left_lt_i    (llt),
      .right_key_i  (cell_key[g+1]),
      .right_valid_i(cell_valid[g+1]),
      .right_lt_i   (cell_lt[g+1]),
      .key_o        (cell_key[g]),
      .valid_o      (cell_valid[g]),
      .lt_o         (cell_lt[g]),
      .hit_o        (cell_hit[g]),
      .pos_o        (cell_pos[g])
    );
  end

  // at most one cell marks the lower bound, so an OR collects it
  always_comb begin
    pos_all = '0;
    present = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_all = pos_all | cell_pos[i];
      present = present | cell_hit[i];
    end
  end

  assign full = (cnt_q == PosW'(CAPACITY));

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    status_d = STAT_OK;
    ctrl     = '0;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_CMP;
      end
      S_CMP: begin
        ctrl.cmp = 1'b1;
        state_d  = S_UPD;
      end
      S_UPD: begin
        state_d = S_IDLE;
        case (op_q)
          OP_INSERT: begin
            if (present) begin
              status_d = STAT_DUP;
            end else if (full) begin
              status_d = STAT_FULL;
            end else begin
              ctrl.ins = 1'b1;
              cnt_d    = cnt_q + PosW'(1);
            end
          end
          OP_DELETE: begin
            if (present) begin
              ctrl.del = 1'b1;
              cnt_d    = cnt_q - PosW'(1);
            end else begin
              status_d = STAT_MISS;
            end
          end
          default: begin
            status_d = present ? STAT_OK : STAT_MISS;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  logic [PosW+FIELD_W-1:0] cnt_ext, pos_ext;
  assign cnt_ext = {{FIELD_W{1'b0}}, cnt_d};
  assign pos_ext = {{FIELD_W{1'b0}}, pos_all};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= (state_q == S_UPD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q  <= operation_i;
      key_q <= key_i[KEY_BITS-1:0];
    end
    if (state_q == S_UPD) begin
      status_q  <= status_d;
      pos_q     <= pos_ext[FIELD_W-1:0];
      cnt_out_q <= cnt_ext[FIELD_W-1:0];
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = res_valid_q;
  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign entry_count_o = cnt_out_q;

endmodule
`default_nettype wire

FILE: sv/sks_checker.sv
`default_nettype none
`include "sorted_key_set_core_macros.svh"
module sks_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        valid_o,
  input wire logic [sks_pkg::FIELD_W-1:0] position_o,
  input wire logic [sks_pkg::FIELD_W-1:0] entry_count_o
);
  import sks_pkg::*;

  // an accepted word keeps the block busy in the next cycle
  `SKS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // a result only shows once the operation is over
  `SKS_ASSERT_IMP(a_result_idle, clk_i, rst_ni, valid_o, !busy)
  // one result per word, never two in a row
  `SKS_ASSERT_NEXT(a_single_result, clk_i, rst_ni, valid_o, !valid_o)
  // lower bound never lies past the stored entries
  `SKS_ASSERT_IMP(a_pos_in_range, clk_i, rst_ni, valid_o, position_o <= entry_count_o)

endmodule

bind sorted_key_set_core sks_checker u_sks_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .position_o   (position_o),
  .entry_count_o(entry_count_o)
);
`default_nettype wire
